/* rtl/pbwq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbwq_pkg - shared types for the power button window qualifier
// Register widths, reset values, event codes and the state record.
// ----------------------------------------------------------------------------
package pbwq_pkg;

   localparam int unsigned WinWidth   = 10;
   localparam int unsigned ThrWidth   = 11;
   localparam int unsigned CountWidth = 11;
   localparam int unsigned CsrWidth   = 11;

   localparam logic [WinWidth-1:0] WinReset    = 10'd100;
   localparam logic [ThrWidth-1:0] OnThrReset  = 11'd75;
   localparam logic [ThrWidth-1:0] OffThrReset = 11'd60;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_ON_THRESHOLD  = 2'd1,
      CSR_OFF_THRESHOLD = 2'd2
   } csr_index_type;

   // Event reported with each result
   typedef enum logic [1:0] {
      EVT_NONE = 2'd0,
      EVT_ON   = 2'd1,
      EVT_OFF  = 2'd2
   } evt_type;

   typedef struct packed {
      logic [WinWidth-1:0] window_length;
      logic [ThrWidth-1:0] on_threshold;
      logic [ThrWidth-1:0] off_threshold;
   } cfg_type;

   typedef struct packed {
      logic                  power_is_on;
      logic                  check_active;
      logic                  await_release;
      logic [CountWidth-1:0] tick_count;
      logic [CountWidth-1:0] press_count;
   } state_type;

endpackage

/* rtl/pbwq_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbwq_step - next-state logic for one button sample
// Opens, counts and closes the check window and decides power switching.
// ----------------------------------------------------------------------------
module pbwq_step
   import pbwq_pkg::*;
(
   input  state_type cur,
   input  cfg_type   cfg,
   input  logic      pressed,
   output state_type nxt,
   output evt_type   evt
);

   logic                  opening;
   logic                  counting;
   logic [CountWidth-1:0] tick_inc;
   logic [CountWidth-1:0] press_inc;
   logic                  closing;

   // Window opens on a pressed sample when nothing else is going on
   assign opening   = !cur.await_release && !cur.check_active && pressed;
   assign counting  = !cur.await_release && (cur.check_active || pressed);
   assign tick_inc  = (opening ? '0 : cur.tick_count) + CountWidth'(1);
   assign press_inc = (opening ? '0 : cur.press_count) + CountWidth'(pressed);
   assign closing   = counting && (tick_inc > {1'b0, cfg.window_length});

   always_comb begin
      nxt = cur;
      evt = EVT_NONE;
      if (cur.await_release) begin
         // a released sample ends the wait
         if (!pressed) begin
            nxt.await_release = 1'b0;
         end
      end else if (counting) begin
         nxt.check_active = 1'b1;
         nxt.tick_count   = tick_inc;
         nxt.press_count  = press_inc;
         if (closing) begin
            nxt.check_active = 1'b0;
            nxt.tick_count   = '0;
            nxt.press_count  = '0;
            nxt.await_release = pressed;
            if (!cur.power_is_on) begin
               if (press_inc > cfg.on_threshold) begin
                  nxt.power_is_on = 1'b1;
                  evt = EVT_ON;
               end
            end else if (press_inc > cfg.off_threshold) begin
               nxt.power_is_on = 1'b0;
               evt = EVT_OFF;
            end
         end
      end
   end

endmodule

/* rtl/power_button_window_qualifier_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_button_window_qualifier_core - windowed debounce of a power button
// Qualifies a sampled button level over a counting window and drives power.
// ----------------------------------------------------------------------------
// One button sample is taken per transfer and one result comes back for each,
// carrying the power drive, the switch event of that sample and whether a
// check window is running. Samples are accepted every cycle unless the input
// side stalls. A result is presented from the result register once its
// sample has left the input register. The whole update of the window
// counters and power state fits between the input register and the result
// register. The input side stalls only while a finished result is held back
// by the output side.
// Configuration writes through the csr port take effect on the next sample.
module power_button_window_qualifier_core
   import pbwq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_button_pressed,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_power_enable,
   output logic [1:0]          rsp_event_code,
   output logic                rsp_checking_now,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [CsrWidth-1:0] csr_wdata
);

   logic      in_valid_ff;
   logic      in_button_ff;
   logic      rsp_valid_ff;
   logic      rsp_power_ff;
   evt_type   rsp_event_ff;
   logic      rsp_check_ff;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   evt_type   evt_in;
   logic      advance;
   logic      req_take;

   // Move the held sample to the result register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   pbwq_step u_step (
      .cur     (state_ff),
      .cfg     (cfg_ff),
      .pressed (in_button_ff),
      .nxt     (state_in),
      .evt     (evt_in)
   );

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH: cfg_in.window_length = csr_wdata[WinWidth-1:0];
            CSR_ON_THRESHOLD:  cfg_in.on_threshold  = csr_wdata[ThrWidth-1:0];
            CSR_OFF_THRESHOLD: cfg_in.off_threshold = csr_wdata[ThrWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= WinReset;
         cfg_ff.on_threshold  <= OnThrReset;
         cfg_ff.off_threshold <= OffThrReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_button_ff <= req_button_pressed;
      end
   end

   // Advance qualifier state once per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_power_ff <= state_in.power_is_on;
         rsp_event_ff <= evt_in;
         rsp_check_ff <= state_in.check_active;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_enable = rsp_power_ff;
   assign rsp_event_code   = rsp_event_ff;
   assign rsp_checking_now = rsp_check_ff;

   // A window and a release wait never run together
   a_excl_phase : assert property (@(posedge clock) disable iff (reset)
      state_ff.check_active |-> !state_ff.await_release)
      else $error("check window open while awaiting release");

   // Counters are clear outside a window
   a_idle_clear : assert property (@(posedge clock) disable iff (reset)
      !state_ff.check_active |-> (state_ff.tick_count == '0 && state_ff.press_count == '0))
      else $error("window counters not cleared");

   // Presses never outnumber ticks
   a_press_le_tick : assert property (@(posedge clock) disable iff (reset)
      state_ff.press_count <= state_ff.tick_count)
      else $error("press count above tick count");

   // Event agrees with the reported power level
   a_evt_power : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EVT_ON) |-> rsp_power_ff)
      else $error("switch-on event with power off");

   a_evt_off : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff == EVT_OFF) |-> !rsp_power_ff)
      else $error("switch-off event with power on");

endmodule
